/* design/ffsa_pkg.sv */
// shared types and constants for the first-fit slot-run allocator
// no dependencies; every other file of the block imports this package
package ffsa_pkg;

  // default sizing handed to the top level parameters
  localparam int DEF_MAX_SLOTS  = 512;
  localparam int DEF_SLOT_SHIFT = 23;

  // slot count the pool register holds after reset
  localparam int RESET_SLOTS = 512;

  // used-bit map is stored as rows of this many slots
  localparam int ROW_SLOTS = 8;
  localparam int ROW_SHIFT = 3;
  localparam int CNT_W     = $clog2(ROW_SLOTS + 1);

  // configuration register width
  localparam int CFG_W = 10;

  // request codes
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_PROBE = 2'd2;

  // highest supported resource kind
  localparam logic [1:0] KIND_MAX = 2'd1;

  // request beat
  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] request_bytes;
    logic [1:0]  alloc_kind;
    logic [8:0]  free_start;
    logic [9:0]  free_count;
  } ffsa_in_t;

  // result beat
  typedef struct packed {
    logic        success;
    logic [8:0]  start_slot;
    logic [9:0]  slot_count;
    logic [9:0]  free_slots;
    logic        pool_empty;
  } ffsa_out_t;

endpackage

/* design/ffsa_map_ram.sv */
// used-bit map storage: one row of slots per word, registered read
// per-row valid flags make a cleared row read as all free; uses ffsa_pkg
module ffsa_map_ram import ffsa_pkg::*; #(
  parameter int ROWS = 64,
  parameter int RW   = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 clear,
  input  logic                 we,
  input  logic [RW-1:0]        waddr,
  input  logic [ROW_SLOTS-1:0] wdata,
  input  logic [RW-1:0]        raddr,
  output logic [ROW_SLOTS-1:0] rdata
);

  logic [ROW_SLOTS-1:0] mem [ROWS];
  logic [ROWS-1:0]      row_valid;
  logic [ROW_SLOTS-1:0] rd_raw;
  logic                 rd_vld;

  // row storage and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_raw <= mem[raddr];
    rd_vld <= row_valid[raddr];
  end

  // row valid flags, cleared at once on reset or pool clear
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      row_valid <= '0;
    end else if (we) begin
      row_valid[waddr] <= 1'b1;
    end
  end

  // a row never written reads as all free
  assign rdata = rd_vld ? rd_raw : '0;

endmodule

/* design/ffsa_row_unit.sv */
// shared row unit: scans one map row for a free run and builds the marked
// and cleared versions of the row; uses ffsa_pkg
module ffsa_row_unit import ffsa_pkg::*; #(
  parameter int AW = 11,
  parameter int RW = 6
) (
  input  logic [RW-1:0]        row_idx,
  input  logic [ROW_SLOTS-1:0] row_bits,
  input  logic [AW-1:0]        run_in,
  input  logic [AW-1:0]        need,
  input  logic [AW-1:0]        pool_n,
  input  logic [AW-1:0]        lo,
  input  logic [AW-1:0]        hi,
  output logic                 found,
  output logic [AW-1:0]        found_start,
  output logic [AW-1:0]        run_out,
  output logic [ROW_SLOTS-1:0] set_row,
  output logic [ROW_SLOTS-1:0] clr_row,
  output logic [CNT_W-1:0]     clear_cnt
);

  logic [AW-1:0] base;

  assign base = AW'(row_idx) << ROW_SHIFT;

  // walk the slots of the row: run length, first fit, range mask
  always_comb begin
    logic [AW-1:0] run;
    logic [AW-1:0] slot;
    logic          free_bit;
    logic          hit;
    run         = run_in;
    found       = 1'b0;
    found_start = '0;
    set_row     = '0;
    clr_row     = '0;
    clear_cnt   = '0;
    for (int j = 0; j < ROW_SLOTS; j++) begin
      slot     = base + AW'(j);
      free_bit = !row_bits[j] && (slot < pool_n);
      run      = free_bit ? run + 1'b1 : '0;
      if (!found && free_bit && (run == need)) begin
        found       = 1'b1;
        found_start = slot + AW'(1) - need;
      end
      hit        = (slot >= lo) && (slot < hi);
      set_row[j] = row_bits[j] | hit;
      clr_row[j] = row_bits[j] & !hit;
      if (row_bits[j] && hit) begin
        clear_cnt = clear_cnt + 1'b1;
      end
    end
    run_out = run;
  end

endmodule

/* design/first_fit_slot_run_allocator_core.sv */
// First-fit slot-run allocator. One request beat is taken at a time and
// walks the used-bit map one row of 8 slots per cycle through a single
// shared row unit: the request is sized and checked, an allocation or probe
// scans rows from the lowest-free hint up to the run found (at most
// ceil(pool/8) rows), an allocation or free marks or clears the rows of its
// run, and the result is loaded into the output register. The map memory
// port paces both the scan and the read-modify-write of rows. in_stall stays
// high until the result is loaded into the output register, and a result
// that waits there does not hold off the next request. A write of the pool
// size register clears the whole pool in the same cycle.
// uses ffsa_pkg, ffsa_map_ram and ffsa_row_unit
module first_fit_slot_run_allocator_core import ffsa_pkg::*; #(
  parameter int MAX_SLOTS  = DEF_MAX_SLOTS,
  parameter int SLOT_SHIFT = DEF_SLOT_SHIFT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  ffsa_in_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output ffsa_out_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int CW   = $clog2(MAX_SLOTS + 1);
  localparam int AW   = (CW > 10) ? CW + 1 : 11;
  localparam int ROWS = (MAX_SLOTS + ROW_SLOTS - 1) / ROW_SLOTS;
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int RH   = RW + ROW_SHIFT - 1;

  localparam logic [32:0]   ROUND     = 33'((64'd1 << SLOT_SHIFT) - 64'd1);
  localparam logic [32:0]   MAX_W     = 33'(MAX_SLOTS);
  localparam logic [AW-1:0] MAX_A     = AW'(MAX_SLOTS);
  localparam logic [AW-1:0] RESET_N   = (RESET_SLOTS > MAX_SLOTS) ? AW'(MAX_SLOTS)
                                                                : AW'(RESET_SLOTS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_CHECK,
    ST_SEARCH,
    ST_MODIFY,
    ST_DONE
  } state_t;

  state_t        state;
  ffsa_in_t      item;
  logic [AW-1:0] pool_n;
  logic [AW-1:0] free_total;
  logic [AW-1:0] hint;
  logic [AW-1:0] need;
  logic [AW-1:0] run;
  logic [AW-1:0] lo;
  logic [AW-1:0] hi;
  logic          mod_set;
  logic [RW-1:0] eval_row;
  logic          res_ok;
  logic [AW-1:0] res_start;
  logic [AW-1:0] res_cnt;

  logic                 cfg_write;
  logic                 in_take;
  logic [AW-1:0]        cfg_n;
  logic [32:0]          need_sum;
  logic [32:0]          need_wide;
  logic [AW-1:0]        need_c;
  logic [AW-1:0]        free_end;
  logic [AW-1:0]        pool_last;
  logic [AW-1:0]        hi_last;
  logic                 alloc_ok;
  logic                 free_ok;
  logic                 search_last;
  logic                 mod_last;
  logic                 is_alloc;

  logic                 mem_we;
  logic [RW-1:0]        mem_raddr;
  logic [ROW_SLOTS-1:0] mem_wdata;
  logic [ROW_SLOTS-1:0] mem_rdata;

  logic                 ru_found;
  logic [AW-1:0]        ru_start;
  logic [AW-1:0]        ru_run;
  logic [ROW_SLOTS-1:0] ru_set;
  logic [ROW_SLOTS-1:0] ru_clr;
  logic [CNT_W-1:0]     ru_cnt;

  // handshakes
  assign cfg_ready = !rst && (state == ST_IDLE);
  assign cfg_write = cfg_valid && cfg_ready;
  assign in_stall  = rst || (state != ST_IDLE) || cfg_valid;
  assign in_take   = in_valid && !in_stall;

  // effective pool size of a register write
  assign cfg_n = (AW'(cfg_data) > MAX_A) ? MAX_A : AW'(cfg_data);

  // byte size rounded up to whole slots, capped just past the pool limit
  assign need_sum  = {1'b0, item.request_bytes} + ROUND;
  assign need_wide = need_sum >> SLOT_SHIFT;
  assign need_c    = (need_wide > MAX_W) ? AW'(MAX_SLOTS + 1) : AW'(need_wide);

  // request checks
  assign is_alloc = (item.opcode == OP_ALLOC);
  assign alloc_ok = ((item.opcode == OP_ALLOC) || (item.opcode == OP_PROBE)) &&
                    (item.request_bytes != '0) && (item.alloc_kind <= KIND_MAX) &&
                    (need <= pool_n) && (need <= free_total);
  assign free_end = AW'(item.free_start) + AW'(item.free_count);
  assign free_ok  = (item.opcode == OP_FREE) && (item.free_count != '0) &&
                    (free_end <= pool_n);

  // last rows of the scan and of the modify pass
  assign pool_last   = pool_n - AW'(1);
  assign hi_last     = hi - AW'(1);
  assign search_last = (eval_row == pool_last[RH:ROW_SHIFT]);
  assign mod_last    = (eval_row == hi_last[RH:ROW_SHIFT]);

  // map memory control
  always_comb begin
    mem_raddr = eval_row;
    mem_we    = 1'b0;
    mem_wdata = mod_set ? ru_set : ru_clr;
    case (state)
      ST_CHECK: begin
        if (alloc_ok) begin
          mem_raddr = hint[RH:ROW_SHIFT];
        end else if (free_ok) begin
          mem_raddr = RW'(AW'(item.free_start) >> ROW_SHIFT);
        end
      end
      ST_SEARCH: begin
        if (ru_found && is_alloc) begin
          mem_raddr = ru_start[RH:ROW_SHIFT];
        end else if (!ru_found && !search_last) begin
          mem_raddr = eval_row + 1'b1;
        end
      end
      ST_MODIFY: begin
        mem_we = 1'b1;
        if (!mod_last) begin
          mem_raddr = eval_row + 1'b1;
        end
      end
      default: begin
        mem_raddr = eval_row;
      end
    endcase
  end

  ffsa_map_ram #(
    .ROWS (ROWS),
    .RW   (RW)
  ) u_map (
    .clk   (clk),
    .rst   (rst),
    .clear (cfg_write),
    .we    (mem_we),
    .waddr (eval_row),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ffsa_row_unit #(
    .AW (AW),
    .RW (RW)
  ) u_row (
    .row_idx     (eval_row),
    .row_bits    (mem_rdata),
    .run_in      (run),
    .need        (need),
    .pool_n      (pool_n),
    .lo          (lo),
    .hi          (hi),
    .found       (ru_found),
    .found_start (ru_start),
    .run_out     (ru_run),
    .set_row     (ru_set),
    .clr_row     (ru_clr),
    .clear_cnt   (ru_cnt)
  );

  // sequencer, pool state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pool_n     <= RESET_N;
      free_total <= RESET_N;
      hint       <= '0;
      out_valid  <= 1'b0;
    end else begin
      if ((state == ST_DONE) && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cfg_write) begin
            pool_n     <= cfg_n;
            free_total <= cfg_n;
            hint       <= '0;
          end else if (in_take) begin
            item  <= in_data;
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          need  <= need_c;
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          res_start <= '0;
          res_cnt   <= '0;
          run       <= '0;
          if (alloc_ok) begin
            res_ok   <= 1'b0;
            eval_row <= hint[RH:ROW_SHIFT];
            state    <= ST_SEARCH;
          end else if (free_ok) begin
            lo       <= AW'(item.free_start);
            hi       <= free_end;
            mod_set  <= 1'b0;
            eval_row <= RW'(AW'(item.free_start) >> ROW_SHIFT);
            res_ok   <= 1'b1;
            if (AW'(item.free_start) < hint) begin
              hint <= AW'(item.free_start);
            end
            state <= ST_MODIFY;
          end else begin
            res_ok <= 1'b0;
            state  <= ST_DONE;
          end
        end
        ST_SEARCH: begin
          if (ru_found) begin
            res_ok  <= 1'b1;
            res_cnt <= need;
            if (is_alloc) begin
              res_start  <= ru_start;
              lo         <= ru_start;
              hi         <= ru_start + need;
              mod_set    <= 1'b1;
              eval_row   <= ru_start[RH:ROW_SHIFT];
              free_total <= free_total - need;
              if (ru_start == hint) begin
                hint <= ru_start + need;
              end
              state <= ST_MODIFY;
            end else begin
              state <= ST_DONE;
            end
          end else if (search_last) begin
            state <= ST_DONE;
          end else begin
            run      <= ru_run;
            eval_row <= eval_row + 1'b1;
          end
        end
        ST_MODIFY: begin
          if (!mod_set) begin
            free_total <= free_total + AW'(ru_cnt);
          end
          if (mod_last) begin
            state <= ST_DONE;
          end else begin
            eval_row <= eval_row + 1'b1;
          end
        end
        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            out_data.success    <= res_ok;
            out_data.start_slot <= res_start[8:0];
            out_data.slot_count <= res_cnt[9:0];
            out_data.free_slots <= free_total[9:0];
            out_data.pool_empty <= (free_total == pool_n);
            state               <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
